// ===== rtl/core/ddo_pkg.sv =====
// ============================================================================
// ddo_pkg
// Shared types, widths and the month-length table for the date offset core.
// ============================================================================
package ddo_pkg;

    // Field widths of the item payloads.
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int OFF_W   = 17;
    localparam int NUM_W   = 16;

    // Signed width of the running day count plus offset. It covers 800 years
    // of days plus the largest offset with room for the sign.
    localparam int ACC_W   = 20;

    // Width of one year length (365 or 366).
    localparam int YLEN_W  = 9;

    // Month codes used by name.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Day codes used by name.
    localparam logic [DAY_W-1:0] DAY_LEAP = 5'd29;

    // One classified item travelling from the front part to the back part.
    typedef struct packed {
        logic [DAY_W-1:0]          start_day;
        logic [MONTH_W-1:0]        start_month;
        logic [YEAR_W-1:0]         start_year;
        logic signed [OFF_W-1:0]   offset_days;
        logic                      fmt_ok;   // month, year and day plausible
        logic                      feb29;    // date is 29 February
    } t_job;

    // Length of month m; m outside 1..12 gives the longest month.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd2:                      len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== rtl/core/ddo_in_if.sv =====
// ============================================================================
// ddo_in_if
// Input channel: a date and a signed day offset with a valid/ready handshake.
// ============================================================================
interface ddo_in_if;
    import ddo_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [DAY_W-1:0]        start_day;
    logic [MONTH_W-1:0]      start_month;
    logic [YEAR_W-1:0]       start_year;
    logic signed [OFF_W-1:0] offset_days;

    modport source (
        output valid, start_day, start_month, start_year, offset_days,
        input  ready
    );

    modport sink (
        input  valid, start_day, start_month, start_year, offset_days,
        output ready
    );
endinterface

// ===== rtl/core/ddo_out_if.sv =====
// ============================================================================
// ddo_out_if
// Output channel: the resulting date, its day number and a range flag.
// ============================================================================
interface ddo_out_if;
    import ddo_pkg::*;

    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic [NUM_W-1:0]   day_number;
    logic               out_of_range;

    modport source (
        output valid, end_day, end_month, end_year, day_number, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, end_day, end_month, end_year, day_number, out_of_range,
        output ready
    );
endinterface

// ===== rtl/core/ddo_front.sv =====
// ============================================================================
// ddo_front
// Accepts input items, checks month, year and day bounds, and registers the
// classified item for the queue. The leap-year check of 29 February is left
// to the back part, which learns the leap flag while it walks the years.
// ============================================================================
module ddo_front #(
    parameter int EPOCH_YEAR = 1970,
    parameter int LAST_YEAR  = 2099
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ddo_in_if.sink        i_in,
    output ddo_pkg::t_job o_job,
    output logic          o_valid,
    input  logic          i_ready
);
    import ddo_pkg::*;

    localparam logic [YEAR_W-1:0] EPOCH_Y = YEAR_W'(EPOCH_YEAR);
    localparam logic [YEAR_W-1:0] LAST_Y  = YEAR_W'(LAST_YEAR);

    logic r_valid;
    t_job r_job;
    t_job n_job;
    logic mon_ok;
    logic year_ok;
    logic day_ok;

    // The stage takes a new item when it is empty or drains this cycle.
    assign i_in.ready = !r_valid || i_ready;

    // Classify the incoming date against the bounds that need no leap flag.
    always_comb begin
        mon_ok  = (i_in.start_month >= MONTH_JAN) && (i_in.start_month <= MONTH_DEC);
        year_ok = (i_in.start_year >= EPOCH_Y) && (i_in.start_year <= LAST_Y);
        day_ok  = (i_in.start_day != '0) &&
                  (i_in.start_day <= month_len(i_in.start_month, 1'b1));
        n_job.start_day   = i_in.start_day;
        n_job.start_month = i_in.start_month;
        n_job.start_year  = i_in.start_year;
        n_job.offset_days = i_in.offset_days;
        n_job.fmt_ok      = mon_ok && year_ok && day_ok;
        n_job.feb29       = (i_in.start_month == MONTH_FEB) && (i_in.start_day == DAY_LEAP);
    end

    // Valid flag of the classification register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Payload of the classification register.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_job <= n_job;
        end
    end

    assign o_job   = r_job;
    assign o_valid = r_valid;
endmodule

// ===== rtl/core/ddo_queue.sv =====
// ============================================================================
// ddo_queue
// Two-entry queue of classified items between the front and back parts.
// ============================================================================
module ddo_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ddo_pkg::t_job i_job,
    input  logic          i_valid,
    output logic          o_ready,
    output ddo_pkg::t_job o_job,
    output logic          o_valid,
    input  logic          i_pop
);
    import ddo_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end
endmodule

// ===== rtl/core/ddo_back.sv =====
// ============================================================================
// ddo_back
// Sequencer that turns a date into a day number by walking years and months,
// adds the offset, and walks years and months again to rebuild the date.
// Leap years are tracked with modulo-4, -100 and -400 counters of the year.
// ============================================================================
module ddo_back #(
    parameter int EPOCH_YEAR = 1970,
    parameter int LAST_YEAR  = 2099
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ddo_pkg::t_job i_job,
    input  logic          i_valid,
    output logic          o_pop,
    ddo_out_if.source     o_out
);
    import ddo_pkg::*;

    localparam logic [YEAR_W-1:0] EPOCH_Y  = YEAR_W'(EPOCH_YEAR);
    localparam logic [YEAR_W-1:0] LAST_Y   = YEAR_W'(LAST_YEAR);
    localparam logic [1:0]        EPOCH_M4 = 2'(EPOCH_YEAR % 4);
    localparam logic [6:0]        EPOCH_M1 = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0]        EPOCH_M3 = 9'(EPOCH_YEAR % 400);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_YEAR   = 7'b0000010,
        S_MONTH  = 7'b0000100,
        S_ADD    = 7'b0001000,
        S_DYEAR  = 7'b0010000,
        S_DMONTH = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    t_job                  r_job;
    logic [YEAR_W-1:0]     r_y;
    logic [1:0]            r_c4;
    logic [6:0]            r_c100;
    logic [8:0]            r_c400;
    logic [MONTH_W-1:0]    r_m;
    logic [ACC_W-2:0]      r_acc;
    logic [NUM_W-1:0]      r_rem;
    logic [NUM_W-1:0]      r_num;
    logic                  r_oor;
    logic                  r_leap_start;
    logic                  r_out_valid;
    logic [DAY_W-1:0]      r_out_day;
    logic [MONTH_W-1:0]    r_out_month;
    logic [YEAR_W-1:0]     r_out_year;
    logic [NUM_W-1:0]      r_out_num;
    logic                  r_out_oor;

    logic                  leap;
    logic [YLEN_W-1:0]     ylen;
    logic [DAY_W-1:0]      mlen;
    logic [ACC_W-1:0]      sum;
    logic                  sum_ok;
    logic                  out_free;

    // Leap flag and lengths of the year and month under the counters.
    assign leap = ((r_c4 == 2'd0) && (r_c100 != 7'd0)) || (r_c400 == 9'd0);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = month_len(r_m, leap);

    // Day count of the start date plus the sign-extended offset.
    assign sum = {1'b0, r_acc} + {{(ACC_W-DAY_W){1'b0}}, r_job.start_day} +
                 {{(ACC_W-OFF_W){r_job.offset_days[OFF_W-1]}}, r_job.offset_days};
    assign sum_ok = !sum[ACC_W-1] && (sum != '0) && (sum[ACC_W-2:NUM_W] == '0);

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = (r_state == S_IDLE) && i_valid;

    // Next-state decode.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_YEAR;
            S_YEAR:   if (!r_job.fmt_ok) begin
                          n_state = S_DONE;
                      end else if (r_y == r_job.start_year) begin
                          n_state = S_MONTH;
                      end
            S_MONTH:  if (r_m == r_job.start_month) n_state = S_ADD;
            S_ADD:    if (r_job.feb29 && !r_leap_start) begin
                          n_state = S_DONE;
                      end else if (!sum_ok) begin
                          n_state = S_DONE;
                      end else begin
                          n_state = S_DYEAR;
                      end
            S_DYEAR:  if (r_rem >= {{(NUM_W-YLEN_W){1'b0}}, ylen}) begin
                          if (r_y == LAST_Y) n_state = S_DONE;
                      end else begin
                          n_state = S_DMONTH;
                      end
            S_DMONTH: if ((r_m == MONTH_DEC) ||
                          (r_rem < {{(NUM_W-DAY_W){1'b0}}, mlen})) begin
                          n_state = S_DONE;
                      end
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State register and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: year and month walks in both directions.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job  <= i_job;
                r_y    <= EPOCH_Y;
                r_c4   <= EPOCH_M4;
                r_c100 <= EPOCH_M1;
                r_c400 <= EPOCH_M3;
                r_m    <= MONTH_JAN;
                r_acc  <= '0;
                r_oor  <= 1'b0;
            end
            S_YEAR: begin
                if (!r_job.fmt_ok) begin
                    r_oor <= 1'b1;
                end else if (r_y == r_job.start_year) begin
                    r_leap_start <= leap;
                end else begin
                    r_acc  <= r_acc + {{(ACC_W-1-YLEN_W){1'b0}}, ylen};
                    r_y    <= r_y + YEAR_W'(1);
                    r_c4   <= r_c4 + 2'd1;
                    r_c100 <= (r_c100 == 7'd99) ? 7'd0 : r_c100 + 7'd1;
                    r_c400 <= (r_c400 == 9'd399) ? 9'd0 : r_c400 + 9'd1;
                end
            end
            S_MONTH: begin
                if (r_m != r_job.start_month) begin
                    r_acc <= r_acc + {{(ACC_W-1-DAY_W){1'b0}}, mlen};
                    r_m   <= r_m + MONTH_W'(1);
                end
            end
            S_ADD: begin
                r_num  <= sum[NUM_W-1:0];
                r_rem  <= sum[NUM_W-1:0] - NUM_W'(1);
                r_y    <= EPOCH_Y;
                r_c4   <= EPOCH_M4;
                r_c100 <= EPOCH_M1;
                r_c400 <= EPOCH_M3;
                r_m    <= MONTH_JAN;
                if ((r_job.feb29 && !r_leap_start) || !sum_ok) begin
                    r_oor <= 1'b1;
                end
            end
            S_DYEAR: begin
                if (r_rem >= {{(NUM_W-YLEN_W){1'b0}}, ylen}) begin
                    if (r_y == LAST_Y) begin
                        r_oor <= 1'b1;
                    end else begin
                        r_rem  <= r_rem - {{(NUM_W-YLEN_W){1'b0}}, ylen};
                        r_y    <= r_y + YEAR_W'(1);
                        r_c4   <= r_c4 + 2'd1;
                        r_c100 <= (r_c100 == 7'd99) ? 7'd0 : r_c100 + 7'd1;
                        r_c400 <= (r_c400 == 9'd399) ? 9'd0 : r_c400 + 9'd1;
                    end
                end
            end
            S_DMONTH: begin
                if ((r_m != MONTH_DEC) &&
                    (r_rem >= {{(NUM_W-DAY_W){1'b0}}, mlen})) begin
                    r_rem <= r_rem - {{(NUM_W-DAY_W){1'b0}}, mlen};
                    r_m   <= r_m + MONTH_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: the rebuilt date, or the input echoed when out of range.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            if (r_oor) begin
                r_out_day   <= r_job.start_day;
                r_out_month <= r_job.start_month;
                r_out_year  <= r_job.start_year;
                r_out_num   <= '0;
                r_out_oor   <= 1'b1;
            end else begin
                r_out_day   <= r_rem[DAY_W-1:0] + DAY_W'(1);
                r_out_month <= r_m;
                r_out_year  <= r_y;
                r_out_num   <= r_num;
                r_out_oor   <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.end_day      = r_out_day;
    assign o_out.end_month    = r_out_month;
    assign o_out.end_year     = r_out_year;
    assign o_out.day_number   = r_out_num;
    assign o_out.out_of_range = r_out_oor;
endmodule

// ===== rtl/core/date_day_offset_core.sv =====
// One item is in the sequencer at a time; it walks the years and months once to
//   find the day count and once more to rebuild the end date.
// The front stage and a two-entry queue take further items while one is at work.
// Reset (synchronous, active low) empties the front stage, queue and output.
// ============================================================================
// date_day_offset_core
// Adds a signed day offset to a Gregorian date and returns the new date and
// its 1-based day number counted from 1 January of the epoch year.
// ============================================================================
module date_day_offset_core #(
    parameter int EPOCH_YEAR = 1970,
    parameter int LAST_YEAR  = 2099
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ddo_in_if.sink    i_in,
    ddo_out_if.source o_out
);
    import ddo_pkg::*;

    t_job front_job;
    logic front_valid;
    logic front_ready;
    t_job queue_job;
    logic queue_valid;
    logic queue_pop;

    // Front part: accepts and classifies items.
    ddo_front #(
        .EPOCH_YEAR (EPOCH_YEAR),
        .LAST_YEAR  (LAST_YEAR)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_job   (front_job),
        .o_valid (front_valid),
        .i_ready (front_ready)
    );

    // Queue between front and back parts.
    ddo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (front_job),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .o_job   (queue_job),
        .o_valid (queue_valid),
        .i_pop   (queue_pop)
    );

    // Back part: day-count sequencer and output register.
    ddo_back #(
        .EPOCH_YEAR (EPOCH_YEAR),
        .LAST_YEAR  (LAST_YEAR)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (queue_job),
        .i_valid (queue_valid),
        .o_pop   (queue_pop),
        .o_out   (o_out)
    );
endmodule

// ===== tb/date_day_offset_core_tb.sv =====
// ============================================================================
// date_day_offset_core_tb
// Drives dates with signed day offsets into the core and checks each result
// against a date predictor in the bench. Runs directed corner cases, then
// random items with random idling on both sides and one long output stall.
// ============================================================================
module date_day_offset_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddo_pkg::*;

    localparam int EPOCH_YEAR   = 1970;
    localparam int LAST_YEAR    = 2099;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 3000;
    localparam int HOLD_AFTER   = 200;
    localparam int CYCLE_LIMIT  = 3000000;

    // One date with its offset, as it goes into the core.
    typedef struct packed {
        logic [DAY_W-1:0]   start_day;
        logic [MONTH_W-1:0] start_month;
        logic [YEAR_W-1:0]  start_year;
        logic [OFF_W-1:0]   offset_days;
    } t_date_req;

    // One shifted date, as it comes out of the core.
    typedef struct packed {
        logic [DAY_W-1:0]   end_day;
        logic [MONTH_W-1:0] end_month;
        logic [YEAR_W-1:0]  end_year;
        logic [NUM_W-1:0]   day_number;
        logic               out_of_range;
    } t_date_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ddo_in_if  in_if ();
    ddo_out_if out_if ();

    date_day_offset_core #(
        .EPOCH_YEAR (EPOCH_YEAR),
        .LAST_YEAR  (LAST_YEAR)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_date_req date_pending_q[$];
    t_date_res shifted_date_q[$];

    int total_items   = 0;
    int sent_count    = 0;
    int result_count  = 0;
    int err_count     = 0;
    int cycle_count   = 0;
    int rx_hold_left  = 0;
    bit rx_hold_done  = 1'b0;

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Calendar arithmetic for the predictor.
    // ------------------------------------------------------------------------
    function automatic bit is_leap_year(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int year_days(input int y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    function automatic int month_days(input int m, input int y);
        int len;
        case (m)
            int'(MONTH_FEB): len = is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11:     len = 30;
            default:         len = 31;
        endcase
        return len;
    endfunction

    // 1-based day count of a valid date, 1 January of the epoch year is 1.
    function automatic int day_count(input int d, input int m, input int y);
        int n;
        n = d;
        for (int yy = EPOCH_YEAR; yy < y; yy++) n += year_days(yy);
        for (int mm = 1; mm < m; mm++) n += month_days(mm, y);
        return n;
    endfunction

    // Expected result for one input item.
    function automatic t_date_res shift_date(input t_date_req req);
        int d, m, y, off, n, rem, yr, mo, last_n;
        t_date_res res;
        d   = req.start_day;
        m   = req.start_month;
        y   = req.start_year;
        off = $signed(req.offset_days);

        // Anything that fails falls back to echoing the input date.
        res.end_day      = req.start_day;
        res.end_month    = req.start_month;
        res.end_year     = req.start_year;
        res.day_number   = '0;
        res.out_of_range = 1'b1;

        if (m >= 1 && m <= 12 && y >= EPOCH_YEAR && y <= LAST_YEAR &&
            d >= 1 && d <= month_days(m, y)) begin
            n      = day_count(d, m, y) + off;
            last_n = day_count(31, 12, LAST_YEAR);
            if (n >= 1 && n <= last_n && n <= 65535) begin
                rem = n - 1;
                yr  = EPOCH_YEAR;
                while (rem >= year_days(yr)) begin
                    rem -= year_days(yr);
                    yr++;
                end
                mo = 1;
                while (mo < 12 && rem >= month_days(mo, yr)) begin
                    rem -= month_days(mo, yr);
                    mo++;
                end
                res.end_day      = DAY_W'(rem + 1);
                res.end_month    = MONTH_W'(mo);
                res.end_year     = YEAR_W'(yr);
                res.day_number   = NUM_W'(n);
                res.out_of_range = 1'b0;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------------
    task automatic queue_item(input int d, input int m, input int y, input int off);
        t_date_req req;
        req.start_day   = d[DAY_W-1:0];
        req.start_month = m[MONTH_W-1:0];
        req.start_year  = y[YEAR_W-1:0];
        req.offset_days = off[OFF_W-1:0];
        date_pending_q.push_back(req);
        total_items++;
    endtask

    task automatic queue_random_item();
        int d, m, y, off, kind, last_n;
        kind   = $urandom_range(0, 9);
        last_n = day_count(31, 12, LAST_YEAR);
        y = $urandom_range(EPOCH_YEAR, LAST_YEAR);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_days(m, y));
        case (kind)
            0, 1, 2, 3: off = int'($urandom_range(0, 800)) - 400;
            4, 5, 6:    off = int'($urandom_range(0, 2 * last_n)) - last_n;
            7: begin
                // Land right around either end of the supported span.
                if ($urandom_range(0, 1) == 0)
                    off = int'($urandom_range(0, 5)) - 2 - day_count(d, m, y) + 1;
                else
                    off = last_n + int'($urandom_range(0, 5)) - 3 - day_count(d, m, y);
            end
            8: off = $urandom_range(0, (1 << OFF_W) - 1);
            default: begin
                // Noise: every field takes raw bits, mostly malformed dates.
                d   = $urandom_range(0, (1 << DAY_W) - 1);
                m   = $urandom_range(0, (1 << MONTH_W) - 1);
                y   = $urandom_range(0, (1 << YEAR_W) - 1);
                off = $urandom_range(0, (1 << OFF_W) - 1);
                if ($urandom_range(0, 1) == 0)
                    y = $urandom_range(EPOCH_YEAR - 2, LAST_YEAR + 2);
            end
        endcase
        queue_item(d, m, y, off);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: presents pending items and records their expected results.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : input_driver
        t_date_req cur_req;
        bit        offering;
        int        tx_gap;
        bit        tx_calm;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            offering = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                shifted_date_q.push_back(shift_date(cur_req));
                sent_count <= sent_count + 1;
                offering = 1'b0;
                tx_calm  = ((sent_count / 150) % 4) == 3;
                tx_gap   = tx_calm ? 0 : $urandom_range(0, 5);
            end
            if (!offering) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (date_pending_q.size() > 0) begin
                    cur_req = date_pending_q.pop_front();
                    in_if.start_day   <= cur_req.start_day;
                    in_if.start_month <= cur_req.start_month;
                    in_if.start_year  <= cur_req.start_year;
                    in_if.offset_days <= cur_req.offset_days;
                    offering = 1'b1;
                end
            end
            in_if.valid <= offering;
        end
    end

    // ------------------------------------------------------------------------
    // Long output stall, once, after a few hundred results have come out.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_left <= 0;
            rx_hold_done <= 1'b0;
        end else if (!rx_hold_done && result_count >= HOLD_AFTER) begin
            rx_hold_left <= HOLD_CYCLES;
            rx_hold_done <= 1'b1;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: checks each result against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_date_res want;
        bit        bad;
        int        rx_gap;
        bit        rx_calm;
        bit        taking;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                bad = 1'b0;
                if (shifted_date_q.size() == 0) begin
                    $display("%0t: unexpected result: day %0d month %0d year %0d num %0d oor %0b",
                             $time, out_if.end_day, out_if.end_month, out_if.end_year,
                             out_if.day_number, out_if.out_of_range);
                    bad = 1'b1;
                end else begin
                    want = shifted_date_q.pop_front();
                    if (out_if.end_day !== want.end_day) begin
                        $display("%0t: end_day expected %0d actual %0d",
                                 $time, want.end_day, out_if.end_day);
                        bad = 1'b1;
                    end
                    if (out_if.end_month !== want.end_month) begin
                        $display("%0t: end_month expected %0d actual %0d",
                                 $time, want.end_month, out_if.end_month);
                        bad = 1'b1;
                    end
                    if (out_if.end_year !== want.end_year) begin
                        $display("%0t: end_year expected %0d actual %0d",
                                 $time, want.end_year, out_if.end_year);
                        bad = 1'b1;
                    end
                    if (out_if.day_number !== want.day_number) begin
                        $display("%0t: day_number expected %0d actual %0d",
                                 $time, want.day_number, out_if.day_number);
                        bad = 1'b1;
                    end
                    if (out_if.out_of_range !== want.out_of_range) begin
                        $display("%0t: out_of_range expected %0b actual %0b",
                                 $time, want.out_of_range, out_if.out_of_range);
                        bad = 1'b1;
                    end
                end
                if (bad) err_count <= err_count + 1;
                result_count <= result_count + 1;
                rx_calm = ((result_count / 120) % 4) == 2;
                rx_gap  = rx_calm ? 0 : $urandom_range(0, 5);
            end

            // Ready drops for the drawn gap and during the long stall.
            taking = 1'b0;
            if (rx_hold_left == 0) begin
                if (rx_gap > 0) rx_gap--;
                else taking = 1'b1;
            end
            out_if.ready <= taking;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("date_day_offset_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus list, reset and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int last_n;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.start_day   = '0;
        in_if.start_month = '0;
        in_if.start_year  = '0;
        in_if.offset_days = '0;
        out_if.ready      = 1'b0;
        last_n            = day_count(31, 12, LAST_YEAR);

        // Ends of the span and of the offset range.
        queue_item(1, 1, EPOCH_YEAR, 0);
        queue_item(1, 1, EPOCH_YEAR, -1);
        queue_item(31, 12, LAST_YEAR, 0);
        queue_item(31, 12, LAST_YEAR, 1);
        queue_item(1, 1, EPOCH_YEAR, last_n - 1);
        queue_item(31, 12, LAST_YEAR, -(last_n - 1));
        queue_item(1, 1, EPOCH_YEAR, last_n);
        queue_item(15, 6, 2000, -(1 << (OFF_W - 1)));
        queue_item(15, 6, 2000, (1 << (OFF_W - 1)) - 1);
        // Leap days and month ends.
        queue_item(28, 2, 2000, 1);
        queue_item(29, 2, 2000, 365);
        queue_item(29, 2, 2001, 0);
        queue_item(30, 2, 2000, 0);
        queue_item(31, 4, 2010, 0);
        queue_item(30, 4, 2010, 1);
        queue_item(31, 1, 2050, 0);
        queue_item(31, 12, 1999, 1);
        queue_item(1, 3, 2096, -1);
        // Malformed dates: day zero, bad months, years outside the span.
        queue_item(0, 5, 2010, 0);
        queue_item(1, 0, 2010, 0);
        queue_item(1, 13, 2010, 0);
        queue_item(31, 15, (1 << YEAR_W) - 1, 0);
        queue_item(1, 1, EPOCH_YEAR - 1, 0);
        queue_item(1, 1, LAST_YEAR + 1, 0);
        queue_item(1, 1, 0, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) queue_random_item();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to go in and every result to come back.
        while (sent_count < total_items || shifted_date_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("date_day_offset_core verification clean");
        else
            $display("date_day_offset_core verification failed");
        $finish;
    end

endmodule
